### design/brf_pkg.sv
// Shared field widths, command codes and status codes of the byte ring FIFO.
package brf_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned RING_SIZE_RST = 1024;

  // Command codes; codes above CMD_STATUS behave as status only
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_TAIL  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_HEAD   = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_STATUS     = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

endpackage

### design/brf_ram.sv
// Single-port-write, registered-read byte memory holding the ring slots.
module brf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [brf_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [brf_pkg::DATA_W-1:0] rdata
);
  import brf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/byte_ring_fifo_with_push_front.sv
// Top level of the byte ring FIFO with push-front.
//
// Usage: each input beat on in_* carries one command (push tail, push front,
// pop head, clear, status) and a data byte; each command yields exactly one
// result beat on out_* with the popped byte (zero unless a pop succeeded),
// the byte count, the free space and a status code. A push into a full ring
// or a pop from an empty one is rejected with a status code and changes
// nothing. cfg_we/cfg_wdata set the ring size (clamped to 2..DEPTH) and
// empty the queue; write it only while the block is idle.
// The result is registered and appears in the cycle after the command beat.
// Throughput: one command per cycle; the indices and count update in the
// accepting cycle and the ring memory's registered read port delivers the
// popped byte with the result, so consecutive pops and pushes do not wait.
// Stall: the result register holds while out_ready is low; in_ready stays
// high only when that register is empty or being taken in the same cycle.
// Reset: head, tail and count clear, ring size returns to 1024 (clamped to
// DEPTH); memory contents are left as they are and never read unwritten.
module byte_ring_fifo_with_push_front #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [brf_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [brf_pkg::CMD_W-1:0]   in_cmd,
  input  logic [brf_pkg::DATA_W-1:0]  in_data_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brf_pkg::DATA_W-1:0]  out_data_out,
  output logic [brf_pkg::CNT_W-1:0]   out_fill_count,
  output logic [brf_pkg::CNT_W-1:0]   out_free_space,
  output logic [brf_pkg::STAT_W-1:0]  out_status
);
  import brf_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned SW   = $clog2(DEPTH + 1);
  localparam int unsigned CW   = (SW > CFG_W) ? SW : CFG_W;
  localparam int unsigned RST_SLOTS = (RING_SIZE_RST > DEPTH) ? DEPTH : RING_SIZE_RST;
  localparam logic [AW-1:0] RST_LAST = AW'(RST_SLOTS - 1);

  // control state
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] cnt_r,  cnt_nxt;
  logic [AW-1:0] last_r, last_nxt;   // slots in use minus one
  logic          out_valid_r;

  // result payload
  logic          pop_ok_r, pop_ok_nxt;
  logic [CNT_W-1:0] fill_r, free_r;
  status_t       status_r, status_nxt;

  logic          accept;
  logic          full, empty;
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] slots_clamped;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [AW-1:0] head_inc, head_dec, tail_inc;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full     = (cnt_r == last_r);
  assign empty    = (cnt_r == '0);

  assign head_inc = (head_r == last_r) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? last_r : head_r - 1'b1;
  assign tail_inc = (tail_r == last_r) ? '0 : tail_r + 1'b1;

  // ring size clamp to 2..DEPTH
  assign cfg_ext = CW'(cfg_wdata);
  always_comb begin
    if (cfg_ext < CW'(2)) begin
      slots_clamped = CW'(2);
    end else if (cfg_ext > CW'(DEPTH)) begin
      slots_clamped = CW'(DEPTH);
    end else begin
      slots_clamped = cfg_ext;
    end
  end

  // command decode and index update
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    pop_ok_nxt = 1'b0;
    status_nxt = STAT_OK;
    ram_we     = 1'b0;
    ram_waddr  = tail_r;
    if (cfg_we) begin
      last_nxt = AW'(slots_clamped - CW'(1));
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else if (accept) begin
      case (in_cmd)
        CMD_PUSH_TAIL: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = tail_inc;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_nxt  = head_dec;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
        CMD_POP_HEAD: begin
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            pop_ok_nxt = 1'b1;
            head_nxt   = head_inc;
            cnt_nxt    = cnt_r - 1'b1;
          end
        end
        CMD_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      last_r      <= RST_LAST;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_ok_r <= pop_ok_nxt;
      status_r <= status_nxt;
      fill_r   <= CNT_W'(cnt_nxt);
      free_r   <= CNT_W'(last_r - cnt_nxt);
    end
  end

  // ring storage; the head slot is read only by a successful pop
  brf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_in),
    .re    (pop_ok_nxt),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_data_out   = pop_ok_r ? ram_rdata : '0;
  assign out_fill_count = fill_r;
  assign out_free_space = free_r;
  assign out_status     = status_r;

endmodule

### design/brf_checker.sv
// Port-level checker for the byte ring FIFO, bound to the top level.
module brf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [brf_pkg::DATA_W-1:0]  out_data_out,
  input logic [brf_pkg::CNT_W-1:0]   out_fill_count,
  input logic [brf_pkg::CNT_W-1:0]   out_free_space,
  input logic [brf_pkg::STAT_W-1:0]  out_status
);
  import brf_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // every command beat gives a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result one cycle after a command beat");

  // a rejected command never returns a byte
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_data_out == '0)
    else $error("rejected command returned data");

  // a full rejection leaves no free space
  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_free_space == '0)
    else $error("push rejected with free space left");

  // an empty rejection reports no held bytes
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_fill_count == '0)
    else $error("pop rejected with bytes held");

endmodule

bind byte_ring_fifo_with_push_front brf_checker u_brf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_data_out   (out_data_out),
  .out_fill_count (out_fill_count),
  .out_free_space (out_free_space),
  .out_status     (out_status)
);

### tb/sv/byte_ring_fifo_with_push_front_chk.sv
// Checker for the byte ring FIFO: tracks ring contents, predicts each result beat and compares.
module byte_ring_fifo_with_push_front_chk
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [DATA_W-1:0]   in_data_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [DATA_W-1:0]   out_data_out,
  input  logic [CNT_W-1:0]    out_fill_count,
  input  logic [CNT_W-1:0]    out_free_space,
  input  logic [STAT_W-1:0]   out_status,
  output int unsigned         results_due,
  output int unsigned         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  free_space;
    status_t           status;
  } ring_result_t;

  // Shadow copy of the ring
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned       head_ptr;
  int unsigned       tail_ptr;
  logic [CFG_W-1:0]  ring_cfg;

  ring_result_t      result_due_q [$];
  int unsigned       mism_cnt;

  // Size register clamped to 2..DEPTH
  function automatic int unsigned slots_in_use();
    if (ring_cfg < 2) return 2;
    if (ring_cfg > DEPTH) return DEPTH;
    return ring_cfg;
  endfunction

  function automatic int unsigned bytes_held(int unsigned slots);
    if (tail_ptr >= head_ptr) return tail_ptr - head_ptr;
    return slots + tail_ptr - head_ptr;
  endfunction

  // Apply one command to the shadow ring and return the result it should produce
  function automatic ring_result_t apply_ring_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] b);
    ring_result_t r;
    int unsigned  slots;
    int unsigned  held;
    slots = slots_in_use();
    held = bytes_held(slots);
    r.data_out = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_PUSH_TAIL: begin
        if (held >= slots - 1) begin
          r.status = STAT_FULL;
        end else begin
          ring_mem[tail_ptr] = b;
          tail_ptr = (tail_ptr + 1 == slots) ? 0 : tail_ptr + 1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (held >= slots - 1) begin
          r.status = STAT_FULL;
        end else begin
          head_ptr = (head_ptr == 0) ? slots - 1 : head_ptr - 1;
          ring_mem[head_ptr] = b;
        end
      end
      CMD_POP_HEAD: begin
        if (held == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data_out = ring_mem[head_ptr];
          head_ptr = (head_ptr + 1 == slots) ? 0 : head_ptr + 1;
        end
      end
      CMD_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
      end
      // status and the unused codes change nothing
      default: ;
    endcase
    held = bytes_held(slots);
    r.fill_count = CNT_W'(held);
    r.free_space = CNT_W'(slots - 1 - held);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mism_cnt++;
    end
  endtask

  // Result beat is checked before the command beat of the same edge: it answers an older one
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      ring_cfg = CFG_W'(RING_SIZE_RST);
      head_ptr = 0;
      tail_ptr = 0;
      result_due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_due_q.size() == 0) begin
          $error("result beat with no command outstanding");
          mism_cnt++;
        end else begin
          want = result_due_q.pop_front();
          check_field("data_out", want.data_out, out_data_out);
          check_field("fill_count", want.fill_count, out_fill_count);
          check_field("free_space", want.free_space, out_free_space);
          check_field("status", want.status, out_status);
        end
      end
      // a size write also empties the ring
      if (cfg_we) begin
        ring_cfg = cfg_wdata;
        head_ptr = 0;
        tail_ptr = 0;
      end
      if (in_valid && in_ready) begin
        result_due_q.push_back(apply_ring_cmd(in_cmd, in_data_in));
      end
    end
    results_due <= result_due_q.size();
    mismatches  <= mism_cnt;
  end

endmodule

### tb/sv/byte_ring_fifo_with_push_front_tb.sv
// Testbench top for the byte ring FIFO: clock, reset, command stimulus, stalls and verdict.
module byte_ring_fifo_with_push_front_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int unsigned RING_DEPTH     = 1024;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_BEATS    = 141;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_STATUS + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd = '0;
  logic [DATA_W-1:0]  in_data_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  out_data_out;
  logic [CNT_W-1:0]   out_fill_count;
  logic [CNT_W-1:0]   out_free_space;
  logic [STAT_W-1:0]  out_status;

  int unsigned results_due;
  int unsigned mismatches;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  byte_ring_fifo_with_push_front #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_fill_count (out_fill_count),
    .out_free_space (out_free_space),
    .out_status     (out_status)
  );

  byte_ring_fifo_with_push_front_chk #(
    .DEPTH(RING_DEPTH)
  ) u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_fill_count (out_fill_count),
    .out_free_space (out_free_space),
    .out_status     (out_status),
    .results_due    (results_due),
    .mismatches     (mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One command beat; valid is left high on return
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_data_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Write the size register once the block has drained
  task automatic set_ring_size(input logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_TAIL;
    if (r < 90) return CMD_POP_HEAD;
    if (r < 92) return CMD_CLEAR;
    if (r < 96) return CMD_STATUS;
    return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
  endfunction

  initial begin
    int unsigned size;
    int unsigned push_pct;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, empty pop
    send_beat(CMD_STATUS, 8'h00);
    send_beat(CMD_POP_HEAD, 8'h00);

    // Capacity two: wrap of push-front, full and empty rejects, clear, unused codes
    set_ring_size(11'd3);
    send_beat(CMD_PUSH_TAIL, 8'h00);
    send_beat(CMD_PUSH_FRONT, 8'hFF);
    send_beat(CMD_PUSH_TAIL, 8'h55);
    send_beat(CMD_PUSH_FRONT, 8'hAA);
    send_beat(CMD_POP_HEAD, 8'h00);
    send_beat(CMD_POP_HEAD, 8'h00);
    send_beat(CMD_POP_HEAD, 8'h00);
    send_beat(CMD_PUSH_TAIL, 8'hA5);
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_STATUS, 8'h00);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE; c++) send_beat(CMD_W'(c), 8'h3C);

    // Size below range clamps to two slots
    set_ring_size(11'd0);
    send_beat(CMD_PUSH_FRONT, 8'h5A);
    send_beat(CMD_PUSH_TAIL, 8'hC3);
    send_beat(CMD_POP_HEAD, 8'h00);
    send_beat(CMD_POP_HEAD, 8'h00);

    // Size above range clamps to DEPTH
    set_ring_size(11'h7FF);
    send_beat(CMD_PUSH_TAIL, 8'h0F);
    send_beat(CMD_PUSH_FRONT, 8'hF0);
    send_beat(CMD_POP_HEAD, 8'h00);

    // Random phases over sizes and idling patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin size = 2;    push_pct = 60; end
        1: begin size = 9;    push_pct = 40; end
        2: begin size = 1024; push_pct = 70; end
        3: begin size = 1;    push_pct = 45; end
        4: begin size = 33;   push_pct = 55; end
        5: begin size = 2047; push_pct = 65; end
        6: begin size = 1025; push_pct = 70; end
        default: begin size = $urandom_range(2, 128); push_pct = 45; end
      endcase
      set_ring_size(CFG_W'(size));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 68; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 68; end
        default: begin send_idle_pct = 23; stall_pct <= 23; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // long receiver hold while commands keep coming
        if (ph == 0 && n == 40) begin
          in_valid   <= 1'b0;
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
        send_beat(pick_cmd(push_pct), DATA_W'($urandom_range(0, 255)));
      end
    end

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
